@@ src/climatology_gap_fill_pixel_assert.svh @@
// Assertion macros used by the checker file of this block.
`ifndef CLIMATOLOGY_GAP_FILL_PIXEL_ASSERT_SVH
`define CLIMATOLOGY_GAP_FILL_PIXEL_ASSERT_SVH

// Clocked property, switched off while reset is held.
`define CGF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must also hold through reset.
`define CGF_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/cgf_pkg.sv @@
package cgf_pkg;

    // Default number of fractional bits of a month weight.
    localparam int CGF_WEIGHT_FRAC_BITS = 16;

    // Field widths of one pixel.
    localparam int CGF_OZ_W = 8;
    localparam int CGF_VP_W = 16;

    // Stream beat widths.
    localparam int CGF_S_TDATA_W = 4 * CGF_OZ_W + 4 * CGF_VP_W;
    localparam int CGF_M_TDATA_W = CGF_OZ_W + CGF_VP_W;

    // Configuration port.
    localparam int CGF_ADDR_W = 4;
    localparam int CGF_DATA_W = 32;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx CGF_REG_PREV   = 2'd0;
    localparam t_reg_idx CGF_REG_TARGET = 2'd1;
    localparam t_reg_idx CGF_REG_NEXT   = 2'd2;

endpackage

@@ src/climatology_gap_fill_pixel.sv @@
// A beat taken on the slave side passes through the weight transfer, multiply, and sum
// and saturate registers in turn before it is shown on the master side.
// Throughput: one pixel per cycle while the master side takes results; three register
// stages (weight transfer, multiply, sum and saturate) each hold one pixel, and any
// stage with a free slot takes a new one. Reset (i_rst_n low, synchronous) empties
// every stage and sets the month weights to one half, one half and zero.
module climatology_gap_fill_pixel
    import cgf_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = CGF_WEIGHT_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Pixel input stream.
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // s_tdata, lowest bit first: ozone_value[7:0], vapor_value[23:8],
    // prev_ozone_avg[31:24], target_ozone_avg[39:32], next_ozone_avg[47:40],
    // prev_vapor_avg[63:48], target_vapor_avg[79:64], next_vapor_avg[95:80].
    input  logic [CGF_S_TDATA_W-1:0] s_tdata,
    // Result stream.
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // m_tdata, lowest bit first: ozone_result[7:0], vapor_result[23:8].
    output logic [CGF_M_TDATA_W-1:0] m_tdata,
    // m_tuser: was_filled[0].
    output logic                     m_tuser,
    // Configuration port; registers at 0x0 (previous), 0x4 (target), 0x8 (next).
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CGF_ADDR_W-1:0]    paddr,
    input  logic [CGF_DATA_W-1:0]    pwdata,
    output logic [CGF_DATA_W-1:0]    prdata,
    output logic                     pready
);

    // A stored weight holds 1.0 exactly, so it needs one integer bit. After the
    // transfers a weight can have taken up both others, which needs two more bits.
    localparam int WBITS = WEIGHT_FRAC_BITS + 1;
    localparam int WW    = WBITS + 2;
    localparam int PO_W  = CGF_OZ_W + WW;
    localparam int PV_W  = CGF_VP_W + WW;
    localparam int SO_W  = PO_W + 2;
    localparam int SV_W  = PV_W + 2;

    localparam logic [WW-1:0]    ONE       = {{(WW - 1){1'b0}}, 1'b1} << WEIGHT_FRAC_BITS;
    localparam logic [WBITS-1:0] HALF      = {{(WBITS - 1){1'b0}}, 1'b1} << (WEIGHT_FRAC_BITS - 1);
    localparam logic [WBITS-1:0] WZERO     = '0;

    typedef struct packed {
        logic [WW-1:0] p;
        logic [WW-1:0] t;
        logic [WW-1:0] n;
    } t_wts;

    // Moves the weight of each fill average in turn, previous month first. Each
    // check sees the weights left by the checks before it.
    function automatic t_wts xfer(input logic zp, input logic zt, input logic zn,
                                  input t_wts w);
        t_wts r;
        r = w;
        if (zp) begin
            if (!zt && !zn) begin
                if (r.t >= r.n) r.t = r.t + r.p;
                else            r.n = r.n + r.p;
            end else if (!zt) begin
                r.t = ONE;
            end else if (!zn) begin
                r.n = ONE;
            end
        end
        if (zt) begin
            if (!zp && !zn) begin
                if (r.p >= r.n) r.p = r.p + r.t;
                else            r.n = r.n + r.t;
            end else if (!zp) begin
                r.p = ONE;
            end else if (!zn) begin
                r.n = ONE;
            end
        end
        if (zn) begin
            if (!zp && !zt) begin
                if (r.p >= r.t) r.p = r.p + r.n;
                else            r.t = r.t + r.n;
            end else if (!zp) begin
                r.p = ONE;
            end else if (!zt) begin
                r.t = ONE;
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Configuration registers.
    // ---------------------------------------------------------------------
    logic [WBITS-1:0] r_prev_w;
    logic [WBITS-1:0] r_target_w;
    logic [WBITS-1:0] r_next_w;
    logic             cfg_wr;
    t_reg_idx         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[CGF_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_w   <= HALF;
            r_target_w <= HALF;
            r_next_w   <= WZERO;
        end else if (cfg_wr) begin
            case (cfg_idx)
                CGF_REG_PREV:   r_prev_w   <= pwdata[WBITS-1:0];
                CGF_REG_TARGET: r_target_w <= pwdata[WBITS-1:0];
                CGF_REG_NEXT:   r_next_w   <= pwdata[WBITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            CGF_REG_PREV:   prdata = CGF_DATA_W'(r_prev_w);
            CGF_REG_TARGET: prdata = CGF_DATA_W'(r_target_w);
            CGF_REG_NEXT:   prdata = CGF_DATA_W'(r_next_w);
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Stall control. Each stage moves on when it is empty or when the stage
    // after it moves on, so bubbles are squeezed out while the output waits.
    // ---------------------------------------------------------------------
    logic r1_v;
    logic r2_v;
    logic r_m_tvalid;
    logic en1;
    logic en2;
    logic en3;

    assign en3      = !r_m_tvalid || m_tready;
    assign en2      = !r2_v || en3;
    assign en1      = !r1_v || en2;
    assign s_tready = en1;

    // ---------------------------------------------------------------------
    // Stage 1: unpack, mark fill averages and move their weights.
    // ---------------------------------------------------------------------
    logic [CGF_OZ_W-1:0] in_oz;
    logic [CGF_VP_W-1:0] in_vp;
    logic [CGF_OZ_W-1:0] n_oz_pa;
    logic [CGF_OZ_W-1:0] n_oz_ta;
    logic [CGF_OZ_W-1:0] n_oz_na;
    logic [CGF_VP_W-1:0] n_vp_pa;
    logic [CGF_VP_W-1:0] n_vp_ta;
    logic [CGF_VP_W-1:0] n_vp_na;
    logic                pw_zero;
    logic                nw_zero;
    t_wts                cfg_wts;
    t_wts                n_oz_w;
    t_wts                n_vp_w;

    assign in_oz = s_tdata[7:0];
    assign in_vp = s_tdata[23:8];

    // A previous or next month whose weight is zero is not used, so its averages count as fill.
    assign pw_zero = (r_prev_w == WZERO);
    assign nw_zero = (r_next_w == WZERO);

    assign n_oz_pa = pw_zero ? '0 : s_tdata[31:24];
    assign n_oz_ta = s_tdata[39:32];
    assign n_oz_na = nw_zero ? '0 : s_tdata[47:40];
    assign n_vp_pa = pw_zero ? '0 : s_tdata[63:48];
    assign n_vp_ta = s_tdata[79:64];
    assign n_vp_na = nw_zero ? '0 : s_tdata[95:80];

    assign cfg_wts.p = WW'(r_prev_w);
    assign cfg_wts.t = WW'(r_target_w);
    assign cfg_wts.n = WW'(r_next_w);

    assign n_oz_w = xfer(n_oz_pa == '0, n_oz_ta == '0, n_oz_na == '0, cfg_wts);
    assign n_vp_w = xfer(n_vp_pa == '0, n_vp_ta == '0, n_vp_na == '0, cfg_wts);

    logic                r1_fill;
    logic [CGF_OZ_W-1:0] r1_oz;
    logic [CGF_VP_W-1:0] r1_vp;
    logic [CGF_OZ_W-1:0] r1_oz_pa;
    logic [CGF_OZ_W-1:0] r1_oz_ta;
    logic [CGF_OZ_W-1:0] r1_oz_na;
    logic [CGF_VP_W-1:0] r1_vp_pa;
    logic [CGF_VP_W-1:0] r1_vp_ta;
    logic [CGF_VP_W-1:0] r1_vp_na;
    t_wts                r1_oz_w;
    t_wts                r1_vp_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en1) begin
            r1_v <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && s_tvalid) begin
            r1_fill  <= (in_oz == '0);
            r1_oz    <= in_oz;
            r1_vp    <= in_vp;
            r1_oz_pa <= n_oz_pa;
            r1_oz_ta <= n_oz_ta;
            r1_oz_na <= n_oz_na;
            r1_vp_pa <= n_vp_pa;
            r1_vp_ta <= n_vp_ta;
            r1_vp_na <= n_vp_na;
            r1_oz_w  <= n_oz_w;
            r1_vp_w  <= n_vp_w;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: the six average-by-weight products.
    // ---------------------------------------------------------------------
    logic                r2_fill;
    logic [CGF_OZ_W-1:0] r2_oz;
    logic [CGF_VP_W-1:0] r2_vp;
    logic [PO_W-1:0]     r2_oz_pp;
    logic [PO_W-1:0]     r2_oz_tp;
    logic [PO_W-1:0]     r2_oz_np;
    logic [PV_W-1:0]     r2_vp_pp;
    logic [PV_W-1:0]     r2_vp_tp;
    logic [PV_W-1:0]     r2_vp_np;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en2) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r1_v) begin
            r2_fill  <= r1_fill;
            r2_oz    <= r1_oz;
            r2_vp    <= r1_vp;
            r2_oz_pp <= PO_W'(r1_oz_pa) * PO_W'(r1_oz_w.p);
            r2_oz_tp <= PO_W'(r1_oz_ta) * PO_W'(r1_oz_w.t);
            r2_oz_np <= PO_W'(r1_oz_na) * PO_W'(r1_oz_w.n);
            r2_vp_pp <= PV_W'(r1_vp_pa) * PV_W'(r1_vp_w.p);
            r2_vp_tp <= PV_W'(r1_vp_ta) * PV_W'(r1_vp_w.t);
            r2_vp_np <= PV_W'(r1_vp_na) * PV_W'(r1_vp_w.n);
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: sum, drop the fraction, saturate, and pick the original
    // values when the pixel was not a gap.
    // ---------------------------------------------------------------------
    logic [SO_W-1:0]                  oz_sum;
    logic [SV_W-1:0]                  vp_sum;
    logic [SO_W-WEIGHT_FRAC_BITS-1:0] oz_int;
    logic [SV_W-WEIGHT_FRAC_BITS-1:0] vp_int;
    logic [CGF_OZ_W-1:0]              oz_sat;
    logic [CGF_VP_W-1:0]              vp_sat;
    logic [CGF_OZ_W-1:0]              n_oz_res;
    logic [CGF_VP_W-1:0]              n_vp_res;

    assign oz_sum = SO_W'(r2_oz_pp) + SO_W'(r2_oz_tp) + SO_W'(r2_oz_np);
    assign vp_sum = SV_W'(r2_vp_pp) + SV_W'(r2_vp_tp) + SV_W'(r2_vp_np);
    assign oz_int = oz_sum[SO_W-1:WEIGHT_FRAC_BITS];
    assign vp_int = vp_sum[SV_W-1:WEIGHT_FRAC_BITS];

    assign oz_sat = (|oz_int[SO_W-WEIGHT_FRAC_BITS-1:CGF_OZ_W]) ? '1 : oz_int[CGF_OZ_W-1:0];
    assign vp_sat = (|vp_int[SV_W-WEIGHT_FRAC_BITS-1:CGF_VP_W]) ? '1 : vp_int[CGF_VP_W-1:0];

    assign n_oz_res = r2_fill ? oz_sat : r2_oz;
    assign n_vp_res = r2_fill ? vp_sat : r2_vp;

    logic [CGF_M_TDATA_W-1:0] r_m_tdata;
    logic                     r_m_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (en3) begin
            r_m_tvalid <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r2_v) begin
            r_m_tdata <= {n_vp_res, n_oz_res};
            r_m_tuser <= r2_fill;
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;
    assign m_tuser  = r_m_tuser;

endmodule

@@ src/cgf_checker.sv @@
`include "climatology_gap_fill_pixel_assert.svh"

module cgf_checker
    import cgf_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     s_tready,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [CGF_M_TDATA_W-1:0] m_tdata,
    input logic                     m_tuser
);

    // The whole result beat, data and flag together.
    logic [CGF_M_TDATA_W:0] m_beat;

    assign m_beat = {m_tuser, m_tdata};

    // Reset empties the pipeline.
    `CGF_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n |=> !m_tvalid, "result valid after reset")

    // A waiting result is held.
    `CGF_ASSERT(a_hold, i_clk, i_rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_beat), "stalled result changed")

    // With the output slot empty every stage can move, so input is taken.
    `CGF_ASSERT(a_ready, i_clk, i_rst_n, !m_tvalid |-> s_tready, "input stalled with empty output")

    // A pixel passed through unchanged had a non-zero ozone value.
    `CGF_ASSERT(a_pass, i_clk, i_rst_n, m_tvalid && !m_tuser |-> m_tdata[7:0] != 8'd0, "pass-through pixel with zero ozone")

endmodule

bind climatology_gap_fill_pixel cgf_checker u_cgf_checker (.*);
